// ===== rtl/stack_machine_execute_unit_defines.svh =====
// Assertion macros for the file that checks behavior.
// They expect signals named clk and rst_n in the enclosing scope.
`ifndef STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH
`define STACK_MACHINE_EXECUTE_UNIT_DEFINES_SVH

// Same-cycle implication.
`define SME_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("sme assertion failed");

// Next-cycle implication.
`define SME_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("sme assertion failed");

`endif

// ===== rtl/sme_pkg.sv =====
`timescale 1ns / 1ps
package sme_pkg;

  localparam int DATA_DEPTH_DEF = 64;
  localparam int LINK_DEPTH_DEF = 32;
  localparam int MEM_WORDS_DEF  = 256;
  localparam int PC_BITS_DEF    = 16;

  typedef enum logic [4:0] {
    OP_ADD = 5'd0,  OP_AND = 5'd1,  OP_BEZ = 5'd2,  OP_BLS = 5'd3,
    OP_BNZ = 5'd4,  OP_BRA = 5'd5,  OP_BRS = 5'd6,  OP_CEQ = 5'd7,
    OP_CGE = 5'd8,  OP_CGT = 5'd9,  OP_CLE = 5'd10, OP_CLT = 5'd11,
    OP_CNE = 5'd12, OP_DEC = 5'd13, OP_DIV = 5'd14, OP_DUP = 5'd15,
    OP_HLT = 5'd16, OP_INC = 5'd17, OP_JAL = 5'd18, OP_LDA = 5'd19,
    OP_LDI = 5'd20, OP_MOD = 5'd21, OP_MUL = 5'd22, OP_NOT = 5'd23,
    OP_OAR = 5'd24, OP_OUT = 5'd25, OP_PRN = 5'd26, OP_RTN = 5'd27,
    OP_STA = 5'd28, OP_SUB = 5'd29, OP_XOR = 5'd30
  } op_t;

  typedef enum logic [2:0] {
    F_NONE      = 3'd0,
    F_UNDERFLOW = 3'd1,
    F_OVERFLOW  = 3'd2,
    F_DIV_ZERO  = 3'd3,
    F_CALL_OVF  = 3'd4,
    F_CALL_UNF  = 3'd5,
    F_BAD_ADDR  = 3'd6
  } fault_t;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD1, S_RD2, S_EX, S_DIV, S_WB
  } state_t;

  typedef struct packed {
    logic clearing;
    logic capture;
    logic rd2;
    logic exec;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic need_div;
    logic div_done;
    logic out_free;
    logic stopped;
  } ctrl_sts_t;

  function automatic logic is_binary(input op_t c);
    case (c)
      OP_ADD, OP_AND, OP_BLS, OP_BRS, OP_CEQ, OP_CGE, OP_CGT, OP_CLE,
      OP_CLT, OP_CNE, OP_DIV, OP_MOD, OP_MUL, OP_OAR, OP_SUB, OP_XOR: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

endpackage

// ===== rtl/sme_ram.sv =====
`timescale 1ns / 1ps
module sme_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/sme_div.sv =====
`timescale 1ns / 1ps
module sme_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [31:0] dividend,
  input  logic [31:0] divisor,
  output logic        done,
  output logic [31:0] quo,
  output logic [31:0] rem
);

  logic [32:0] rem_r, rem_nxt;
  logic [31:0] quo_r, quo_nxt;
  logic [31:0] dvs_r;
  logic [4:0]  cnt_r;
  logic        busy_r, done_r;
  logic        negq_r, negr_r;
  logic [32:0] shifted, diff;

  // One quotient bit per step, restoring form on magnitudes.
  always_comb begin
    shifted = {rem_r[31:0], quo_r[31]};
    diff    = shifted - {1'b0, dvs_r};
    rem_nxt = diff[32] ? shifted : diff;
    quo_nxt = {quo_r[30:0], ~diff[32]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
        rem_r  <= '0;
        quo_r  <= dividend[31] ? (~dividend + 32'd1) : dividend;
        dvs_r  <= divisor[31] ? (~divisor + 32'd1) : divisor;
        negq_r <= dividend[31] ^ divisor[31];
        negr_r <= dividend[31];
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        quo_r <= quo_nxt;
        cnt_r <= cnt_r + 5'd1;
        if (cnt_r == 5'd31) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done = done_r;
  assign quo  = negq_r ? (~quo_r + 32'd1) : quo_r;
  assign rem  = negr_r ? (~rem_r[31:0] + 32'd1) : rem_r[31:0];

endmodule

// ===== rtl/sme_datapath.sv =====
`timescale 1ns / 1ps
module sme_datapath
  import sme_pkg::*;
#(
  parameter int DATA_DEPTH = DATA_DEPTH_DEF,
  parameter int LINK_DEPTH = LINK_DEPTH_DEF,
  parameter int MEM_WORDS  = MEM_WORDS_DEF,
  parameter int PC_BITS    = PC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  ctrl_cmd_t   cmd,
  output ctrl_sts_t   sts,
  input  logic [39:0] in_tdata,
  input  logic        out_tready,
  output logic        out_tvalid,
  output logic [55:0] out_tdata
);

  localparam int DW  = $clog2(DATA_DEPTH);
  localparam int DDW = $clog2(DATA_DEPTH + 1);
  localparam int LW  = $clog2(LINK_DEPTH);
  localparam int LDW = $clog2(LINK_DEPTH + 1);
  localparam int MAW = $clog2(MEM_WORDS);

  op_t                cmd_r;
  logic [31:0]        opnd_r, top_r;
  logic [DDW-1:0]     dd_r, dd_n, dd_n_r;
  logic [LDW-1:0]     ld_r, ld_n, ld_n_r;
  logic [PC_BITS-1:0] pc_r, nxt, nxt_r;
  logic               stopped_r, stop_n, stop_n_r;
  logic [MAW-1:0]     clr_cnt_r;

  fault_t             f, f_r;
  logic               pv, pv_r;
  logic [31:0]        pval, pval_r;
  logic               ws_en, ws_en_r, lk_en, lk_en_r, mm_en, mm_en_r, need_div;
  logic [DW-1:0]      ws_idx, ws_idx_r;
  logic [31:0]        res, res_r, alu;

  logic [DDW-1:0]     dd_m1, dd_m2;
  logic [LDW-1:0]     ld_m1;
  logic [31:0]        dstk_q, mem_q, a, b;
  logic [PC_BITS-1:0] link_q, target;
  logic               addr_ok, is_dm;
  logic [DW-1:0]      dstk_raddr;
  logic               mem_we;
  logic [MAW-1:0]     mem_waddr;
  logic [31:0]        mem_wdata;
  logic               div_done;
  logic [31:0]        div_quo, div_rem;

  logic               out_valid_r;
  logic [PC_BITS-1:0] o_pc_r;
  logic               o_pv_r, o_halt_r;
  logic [31:0]        o_pval_r, o_pc32;
  fault_t             o_fault_r;

  assign dd_m1      = dd_r - DDW'(1);
  assign dd_m2      = dd_r - DDW'(2);
  assign ld_m1      = ld_r - LDW'(1);
  assign dstk_raddr = cmd.rd2 ? dd_m2[DW-1:0] : dd_m1[DW-1:0];
  assign a          = top_r;
  assign b          = dstk_q;
  assign target     = opnd_r[PC_BITS-1:0] + PC_BITS'(1);
  assign addr_ok    = !opnd_r[31] && (opnd_r < 32'(MEM_WORDS));
  assign is_dm      = (cmd_r == OP_DIV) || (cmd_r == OP_MOD);

  sme_ram #(.WIDTH(32), .DEPTH(DATA_DEPTH)) u_dstk (
    .clk, .we(cmd.commit && ws_en_r), .waddr(ws_idx_r), .wdata(res_r),
    .raddr(dstk_raddr), .rdata(dstk_q)
  );

  sme_ram #(.WIDTH(PC_BITS), .DEPTH(LINK_DEPTH)) u_lstk (
    .clk, .we(cmd.commit && lk_en_r), .waddr(ld_r[LW-1:0]), .wdata(pc_r),
    .raddr(ld_m1[LW-1:0]), .rdata(link_q)
  );

  assign mem_we    = cmd.clearing || (cmd.commit && mm_en_r);
  assign mem_waddr = cmd.clearing ? clr_cnt_r : opnd_r[MAW-1:0];
  assign mem_wdata = cmd.clearing ? 32'd0 : top_r;

  sme_ram #(.WIDTH(32), .DEPTH(MEM_WORDS)) u_wmem (
    .clk, .we(mem_we), .waddr(mem_waddr), .wdata(mem_wdata),
    .raddr(opnd_r[MAW-1:0]), .rdata(mem_q)
  );

  sme_div u_div (
    .clk, .rst_n, .start(cmd.exec && need_div), .dividend(a), .divisor(b),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  always_comb begin
    case (cmd_r)
      OP_ADD:  alu = a + b;
      OP_AND:  alu = a & b;
      OP_BLS:  alu = a << b[4:0];
      OP_BRS:  alu = $signed(a) >>> b[4:0];
      OP_CEQ:  alu = {31'd0, a == b};
      OP_CGE:  alu = {31'd0, $signed(a) >= $signed(b)};
      OP_CGT:  alu = {31'd0, $signed(a) > $signed(b)};
      OP_CLE:  alu = {31'd0, $signed(a) <= $signed(b)};
      OP_CLT:  alu = {31'd0, $signed(a) < $signed(b)};
      OP_CNE:  alu = {31'd0, a != b};
      OP_MUL:  alu = a * b;
      OP_OAR:  alu = a | b;
      OP_SUB:  alu = a - b;
      default: alu = a ^ b;
    endcase
  end

  always_comb begin
    f        = F_NONE;
    nxt      = pc_r + PC_BITS'(1);
    pv       = 1'b0;
    pval     = 32'd0;
    ws_en    = 1'b0;
    ws_idx   = dd_m1[DW-1:0];
    res      = alu;
    dd_n     = dd_r;
    ld_n     = ld_r;
    lk_en    = 1'b0;
    mm_en    = 1'b0;
    stop_n   = stopped_r;
    need_div = 1'b0;
    if (stopped_r) begin
      nxt = pc_r;
    end else if (is_binary(cmd_r)) begin
      if (dd_r < DDW'(2)) begin
        f = F_UNDERFLOW;
      end else if (is_dm && (b == 32'd0)) begin
        f = F_DIV_ZERO;
      end else begin
        ws_en    = 1'b1;
        ws_idx   = dd_m2[DW-1:0];
        dd_n     = dd_m1;
        need_div = is_dm;
      end
    end else begin
      case (cmd_r)
        OP_BEZ, OP_BNZ: begin
          if (dd_r == '0) begin
            f = F_UNDERFLOW;
          end else begin
            dd_n = dd_m1;
            if ((cmd_r == OP_BEZ) == (a == 32'd0)) nxt = target;
          end
        end
        OP_BRA: nxt = target;
        OP_DEC, OP_INC, OP_NOT: begin
          if (dd_r == '0) begin
            f = F_UNDERFLOW;
          end else begin
            ws_en = 1'b1;
            res   = (cmd_r == OP_DEC) ? a - 32'd1 :
                    (cmd_r == OP_INC) ? a + 32'd1 : ~a;
          end
        end
        OP_DUP: begin
          if (dd_r == '0) begin
            f = F_UNDERFLOW;
          end else if (dd_r >= DDW'(DATA_DEPTH)) begin
            f = F_OVERFLOW;
          end else begin
            ws_en  = 1'b1;
            ws_idx = dd_r[DW-1:0];
            res    = a;
            dd_n   = dd_r + DDW'(1);
          end
        end
        OP_HLT: stop_n = 1'b1;
        OP_JAL: begin
          if (ld_r >= LDW'(LINK_DEPTH)) begin
            f = F_CALL_OVF;
          end else begin
            lk_en = 1'b1;
            ld_n  = ld_r + LDW'(1);
            nxt   = target;
          end
        end
        OP_LDA, OP_LDI: begin
          if ((cmd_r == OP_LDA) && !addr_ok) begin
            f = F_BAD_ADDR;
          end else if (dd_r >= DDW'(DATA_DEPTH)) begin
            f = F_OVERFLOW;
          end else begin
            ws_en  = 1'b1;
            ws_idx = dd_r[DW-1:0];
            res    = (cmd_r == OP_LDA) ? mem_q : opnd_r;
            dd_n   = dd_r + DDW'(1);
          end
        end
        OP_OUT: begin
          if (dd_r == '0) begin
            f = F_UNDERFLOW;
          end else begin
            dd_n = dd_m1;
            pv   = 1'b1;
            pval = a;
          end
        end
        OP_RTN: begin
          if (ld_r == '0) begin
            f = F_CALL_UNF;
          end else begin
            ld_n = ld_m1;
            nxt  = link_q + PC_BITS'(1);
          end
        end
        OP_STA: begin
          if (dd_r == '0) begin
            f = F_UNDERFLOW;
          end else if (!addr_ok) begin
            f = F_BAD_ADDR;
          end else begin
            mm_en = 1'b1;
            dd_n  = dd_m1;
          end
        end
        default: ;
      endcase
    end
    if (f != F_NONE) begin
      nxt      = pc_r;
      stop_n   = 1'b1;
      pv       = 1'b0;
      pval     = 32'd0;
      ws_en    = 1'b0;
      lk_en    = 1'b0;
      mm_en    = 1'b0;
      dd_n     = dd_r;
      ld_n     = ld_r;
      need_div = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r  <= op_t'(in_tdata[4:0]);
      opnd_r <= in_tdata[36:5];
    end
    if (cmd.rd2) begin
      top_r <= dstk_q;
    end
    if (cmd.exec) begin
      f_r      <= f;
      nxt_r    <= nxt;
      pv_r     <= pv;
      pval_r   <= pval;
      ws_en_r  <= ws_en;
      ws_idx_r <= ws_idx;
      res_r    <= res;
      dd_n_r   <= dd_n;
      ld_n_r   <= ld_n;
      lk_en_r  <= lk_en;
      mm_en_r  <= mm_en;
      stop_n_r <= stop_n;
    end
    if (div_done) begin
      res_r <= (cmd_r == OP_MOD) ? div_rem : div_quo;
    end
    if (cmd.commit) begin
      o_pc_r    <= nxt_r;
      o_pv_r    <= pv_r;
      o_pval_r  <= pval_r;
      o_halt_r  <= stop_n_r;
      o_fault_r <= f_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dd_r        <= '0;
      ld_r        <= '0;
      pc_r        <= '0;
      stopped_r   <= 1'b0;
      out_valid_r <= 1'b0;
      clr_cnt_r   <= '0;
    end else begin
      if (cmd.clearing) clr_cnt_r <= clr_cnt_r + MAW'(1);
      if (cmd.commit) begin
        dd_r      <= dd_n_r;
        ld_r      <= ld_n_r;
        pc_r      <= nxt_r;
        stopped_r <= stop_n_r;
      end
      if (cmd.commit) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  assign o_pc32 = 32'(o_pc_r);

  assign sts.clr_done = (clr_cnt_r == MAW'(MEM_WORDS - 1));
  assign sts.need_div = need_div;
  assign sts.div_done = div_done;
  assign sts.out_free = !out_valid_r || out_tready;
  assign sts.stopped  = stopped_r;

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {3'd0, o_fault_r, o_halt_r, o_pval_r, o_pv_r, o_pc32[15:0]};

endmodule

// ===== rtl/sme_ctrl.sv =====
`timescale 1ns / 1ps
module sme_ctrl
  import sme_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_tvalid,
  output logic      in_tready,
  input  ctrl_sts_t sts,
  output ctrl_cmd_t cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      S_CLEAR: begin
        cmd.clearing = 1'b1;
        if (sts.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        in_tready   = 1'b1;
        cmd.capture = in_tvalid;
        if (in_tvalid) state_nxt = S_RD1;
      end
      S_RD1: state_nxt = S_RD2;
      S_RD2: begin
        cmd.rd2   = 1'b1;
        state_nxt = S_EX;
      end
      S_EX: begin
        cmd.exec  = 1'b1;
        state_nxt = sts.need_div ? S_DIV : S_WB;
      end
      S_DIV: begin
        if (sts.div_done) state_nxt = S_WB;
      end
      S_WB: begin
        if (sts.out_free) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/stack_machine_execute_unit.sv =====
`timescale 1ns / 1ps
// Channel | Dir | Handshake          | Payload
// in_     | in  | in_tvalid/tready   | in_tdata:  cmd[4:0], operand[36:5]
// out_    | out | out_tvalid/tready  | out_tdata: next_pc, print_valid, print_value,
//         |     |                    |            halted, fault
//
// One instruction at a time. An item goes through accept, top read, second read, execute
// and commit; div and mod add a wait in the bit-serial divider. The data
// stack memory's single read port makes the top and second reads separate steps.
// After reset the word memory is cleared one word a cycle, all MEM_WORDS words, with
// in_tready low. Reset is synchronous, active low.
// A result waiting on out_tready does not block the next accept; commit of the next
// item holds until the output register is free.
module stack_machine_execute_unit
  import sme_pkg::*;
#(
  parameter int DATA_DEPTH = DATA_DEPTH_DEF,
  parameter int LINK_DEPTH = LINK_DEPTH_DEF,
  parameter int MEM_WORDS  = MEM_WORDS_DEF,
  parameter int PC_BITS    = PC_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // cmd[4:0], operand[36:5], zero fill
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [55:0] out_tdata   // next_pc[15:0], print_valid[16], print_value[48:17],
                                  // halted[49], fault[52:50], zero fill
);

`include "stack_machine_execute_unit_defines.svh"

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  // Sequence each transaction through read, execute and commit.
  sme_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .sts, .cmd
  );

  // Hold stacks, word memory, pc and the output register.
  sme_datapath #(
    .DATA_DEPTH(DATA_DEPTH), .LINK_DEPTH(LINK_DEPTH),
    .MEM_WORDS(MEM_WORDS), .PC_BITS(PC_BITS)
  ) u_dp (
    .clk, .rst_n, .cmd, .sts, .in_tdata, .out_tready, .out_tvalid, .out_tdata
  );

  // Only one instruction in flight.
  `SME_ASSERT_NEXT(a_one_at_a_time, in_tvalid && in_tready, !in_tready)
  // Once stopped, stay stopped.
  `SME_ASSERT_NEXT(a_stop_sticks, sts.stopped, sts.stopped)
  // A fault always reports halted.
  `SME_ASSERT_IMPL(a_fault_halts, out_tvalid && (fault_t'(out_tdata[52:50]) != F_NONE), out_tdata[49])

endmodule
